[sv/fsb_pkg.sv]
// Shared types and constants for the frame scaler with brightness gain.
`default_nettype none
package fsb_pkg;

  localparam int unsigned MAX_SRC_WIDTH  = 256;
  localparam int unsigned MAX_SRC_HEIGHT = 256;
  localparam int unsigned MAX_DST_DIM    = 4096;

  localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;
  localparam logic [9:0]  GAIN_MIN     = 10'd26;
  localparam logic [9:0]  GAIN_MAX     = 10'd512;
  localparam logic [9:0]  GAIN_RESET   = 10'd256;

  // Setup divider: 22-bit dividend, one quotient bit per cycle.
  localparam int unsigned SU_NUM_W    = 22;
  localparam logic [4:0]  SU_LAST_BIT = 5'd21;
  // Per-pixel dividers produce eight quotient bits, one per stage.
  localparam int unsigned DIV_STAGES  = 8;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_SCALE_MODE = 3'd4,
    REG_FLIP       = 3'd5,
    REG_GAIN       = 3'd6,
    REG_EDGE_GUARD = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_STRETCH = 2'd0,
    MODE_FIT     = 2'd1,
    MODE_CROP    = 2'd2,
    MODE_SPARE   = 2'd3
  } scale_sel_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ZERO_DIM = 2'd1,
    STATUS_OVERSIZE = 2'd2,
    STATUS_SPARE    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_BLACK  = 2'd2,
    KIND_SAMPLE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    SU_IDLE,
    SU_MULT,
    SU_SEL,
    SU_DIV,
    SU_FIN
  } su_state_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  load_x;
    logic [7:0]  load_y;
    logic [31:0] load_pixel;
    logic [11:0] fetch_x;
    logic [11:0] fetch_y;
  } in_t;

  typedef struct packed {
    logic [31:0] out_pixel;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    status_t     status;
    logic [15:0] addr;
    logic [31:0] pix;
    logic [12:0] remx;
    logic [12:0] remy;
    logic [7:0]  lowx;
    logic [7:0]  lowy;
  } dv_t;

endpackage
`default_nettype wire

[sv/frame_scaler_with_brightness_unit.sv]
// Top level of the nearest-neighbour frame scaler with brightness gain.
// A fetch beat crosses the input, B, divider, C, store and output registers to its result.
// One beat is taken per cycle while busy is low; loads and fetches may be mixed freely.
// After reset and after any register write, a setup pass derives the geometry with a
// single bit-serial divider; busy is high throughout it.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module frame_scaler_with_brightness_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire fsb_pkg::in_t item,
  output fsb_pkg::out_t     result,
  output logic              result_valid,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [12:0]  cfg_data
);

  // Configuration registers.
  logic [8:0]  src_width, src_height;
  logic [12:0] dst_width, dst_height;
  logic [1:0]  scale_mode;
  logic        flip_vertical;
  logic [9:0]  brightness_gain;
  logic [7:0]  edge_guard;

  logic cfg_wr;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width       <= '0;
      src_height      <= '0;
      dst_width       <= '0;
      dst_height      <= '0;
      scale_mode      <= '0;
      flip_vertical   <= 1'b0;
      brightness_gain <= fsb_pkg::GAIN_RESET;
      edge_guard      <= '0;
    end else if (cfg_wr) begin
      unique case (fsb_pkg::reg_index_t'(cfg_index))
        fsb_pkg::REG_SRC_WIDTH:  src_width       <= cfg_data[8:0];
        fsb_pkg::REG_SRC_HEIGHT: src_height      <= cfg_data[8:0];
        fsb_pkg::REG_DST_WIDTH:  dst_width       <= cfg_data;
        fsb_pkg::REG_DST_HEIGHT: dst_height      <= cfg_data;
        fsb_pkg::REG_SCALE_MODE: scale_mode      <= cfg_data[1:0];
        fsb_pkg::REG_FLIP:       flip_vertical   <= cfg_data[0];
        fsb_pkg::REG_GAIN:       brightness_gain <= cfg_data[9:0];
        fsb_pkg::REG_EDGE_GUARD: edge_guard      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Setup sequencer: derives spans, offsets, edge guard and gain once per configuration.
  fsb_pkg::su_state_t su_state, su_state_next;
  logic su_mult, su_sel, su_div, su_fin;

  logic [21:0] prod_a, prod_b;
  logic        wide_src;
  logic [21:0] su_num;
  logic [12:0] su_den, su_rem;
  logic [4:0]  su_cnt;

  // Derived geometry.
  logic [12:0] rw, rh;
  logic [8:0]  spw, sph;
  logic [11:0] dx0, dy0;
  logic [7:0]  sx0, sy0;
  logic [7:0]  guard;
  logic [12:0] dw_guard, dh_guard;
  logic [9:0]  gain_eff;

  always_comb begin
    su_state_next = su_state;
    unique case (su_state)
      fsb_pkg::SU_IDLE: su_state_next = fsb_pkg::SU_IDLE;
      fsb_pkg::SU_MULT: su_state_next = fsb_pkg::SU_SEL;
      fsb_pkg::SU_SEL:  su_state_next = fsb_pkg::SU_DIV;
      fsb_pkg::SU_DIV:  if (su_cnt == fsb_pkg::SU_LAST_BIT) begin
        su_state_next = fsb_pkg::SU_FIN;
      end
      fsb_pkg::SU_FIN:  su_state_next = fsb_pkg::SU_IDLE;
      default:          su_state_next = fsb_pkg::SU_MULT;
    endcase
    if (cfg_wr) begin
      su_state_next = fsb_pkg::SU_MULT;
    end
  end

  always_comb begin
    busy    = (su_state != fsb_pkg::SU_IDLE);
    su_mult = (su_state == fsb_pkg::SU_MULT);
    su_sel  = (su_state == fsb_pkg::SU_SEL);
    su_div  = (su_state == fsb_pkg::SU_DIV);
    su_fin  = (su_state == fsb_pkg::SU_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      su_state <= fsb_pkg::SU_MULT;
    end else begin
      su_state <= su_state_next;
    end
  end

  logic [13:0] su_trial;
  logic        su_ge;
  logic [12:0] su_q;
  logic [7:0]  half_w, half_h, guard_c;

  always_comb begin
    su_trial = {su_rem, su_num[21]};
    su_ge    = (su_trial >= {1'b0, su_den});
    su_q     = (su_num == '0) ? 13'd1 : su_num[12:0];
    half_w   = (dst_width[12:1] > 12'd255)  ? 8'd255 : dst_width[8:1];
    half_h   = (dst_height[12:1] > 12'd255) ? 8'd255 : dst_height[8:1];
    guard_c  = edge_guard;
    if (half_w < guard_c) guard_c = half_w;
    if (half_h < guard_c) guard_c = half_h;
  end

  always_ff @(posedge clk) begin
    if (su_mult) begin
      prod_a <= 22'(src_width * dst_height);
      prod_b <= 22'(src_height * dst_width);
    end
    if (su_sel) begin
      wide_src <= (prod_a > prod_b);
      su_rem   <= '0;
      su_cnt   <= '0;
      case (fsb_pkg::scale_sel_t'(scale_mode))
        fsb_pkg::MODE_FIT: begin
          su_num <= (prod_a > prod_b) ? prod_b : prod_a;
          su_den <= (prod_a > prod_b) ? {4'd0, src_width} : {4'd0, src_height};
        end
        fsb_pkg::MODE_CROP: begin
          su_num <= (prod_a > prod_b) ? prod_b : prod_a;
          su_den <= (prod_a > prod_b) ? dst_height : dst_width;
        end
        default: begin
          su_num <= prod_a;
          su_den <= dst_width;
        end
      endcase
    end
    if (su_div) begin
      su_rem <= su_ge ? 13'(su_trial - {1'b0, su_den}) : su_trial[12:0];
      su_num <= {su_num[20:0], su_ge};
      su_cnt <= su_cnt + 5'd1;
    end
    if (su_fin) begin
      rw  <= dst_width;
      rh  <= dst_height;
      spw <= src_width;
      sph <= src_height;
      dx0 <= '0;
      dy0 <= '0;
      sx0 <= '0;
      sy0 <= '0;
      if (scale_mode == fsb_pkg::MODE_FIT) begin
        if (wide_src) begin
          rh  <= su_q;
          dy0 <= 12'((dst_height - su_q) >> 1);
        end else begin
          rw  <= su_q;
          dx0 <= 12'((dst_width - su_q) >> 1);
        end
      end else if (scale_mode == fsb_pkg::MODE_CROP) begin
        if (wide_src) begin
          spw <= su_q[8:0];
          sx0 <= 8'((src_width - su_q[8:0]) >> 1);
        end else begin
          sph <= su_q[8:0];
          sy0 <= 8'((src_height - su_q[8:0]) >> 1);
        end
      end
      guard    <= guard_c;
      dw_guard <= dst_width - {5'd0, guard_c};
      dh_guard <= dst_height - {5'd0, guard_c};
      if (brightness_gain < fsb_pkg::GAIN_MIN) begin
        gain_eff <= fsb_pkg::GAIN_MIN;
      end else if (brightness_gain > fsb_pkg::GAIN_MAX) begin
        gain_eff <= fsb_pkg::GAIN_MAX;
      end else begin
        gain_eff <= brightness_gain;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Pixel pipeline.
  logic         a_valid;
  fsb_pkg::in_t a_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start & ~busy;
    end
    a_item <= item;
  end

  // Stage A: classify the beat and form the offsets inside the render area.
  fsb_pkg::kind_t   a_kind;
  fsb_pkg::status_t a_status;
  logic [12:0]      a_px, a_py, a_ly;
  logic [11:0]      a_ox, a_oy;

  always_comb begin
    a_px     = {1'b0, a_item.fetch_x};
    a_py     = {1'b0, a_item.fetch_y};
    a_ly     = flip_vertical ? 13'(dst_height - 13'd1 - a_py) : a_py;
    a_ox     = 12'(a_px - {1'b0, dx0});
    a_oy     = 12'(a_ly - {1'b0, dy0});
    a_status = fsb_pkg::STATUS_OK;
    a_kind   = fsb_pkg::KIND_SAMPLE;
    if (src_width == '0 || src_height == '0 || dst_width == '0 || dst_height == '0) begin
      a_status = fsb_pkg::STATUS_ZERO_DIM;
    end else if (src_width > 9'(fsb_pkg::MAX_SRC_WIDTH)
              || src_height > 9'(fsb_pkg::MAX_SRC_HEIGHT)
              || dst_width > 13'(fsb_pkg::MAX_DST_DIM)
              || dst_height > 13'(fsb_pkg::MAX_DST_DIM)) begin
      a_status = fsb_pkg::STATUS_OVERSIZE;
    end
    if (!a_item.operation) begin
      a_kind = fsb_pkg::KIND_LOAD;
    end else if (a_status != fsb_pkg::STATUS_OK) begin
      a_kind = fsb_pkg::KIND_EMPTY;
    end else if (a_px >= dst_width || a_py >= dst_height) begin
      a_kind = fsb_pkg::KIND_EMPTY;
    end else if (a_py < {5'd0, guard} || a_py >= dh_guard
              || a_px < {5'd0, guard} || a_px >= dw_guard) begin
      a_kind = fsb_pkg::KIND_BLACK;
    end else if (a_px < {1'b0, dx0} || a_px >= 13'({1'b0, dx0} + rw)
              || a_ly < {1'b0, dy0} || a_ly >= 13'({1'b0, dy0} + rh)) begin
      a_kind = fsb_pkg::KIND_EMPTY;
    end
  end

  logic             b_valid;
  fsb_pkg::kind_t   b_kind;
  fsb_pkg::status_t b_status;
  logic [15:0]      b_addr;
  logic [31:0]      b_pix;
  logic [11:0]      b_ox, b_oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_kind   <= a_kind;
    b_status <= a_status;
    b_addr   <= {a_item.load_y, a_item.load_x};
    b_pix    <= a_item.load_pixel;
    b_ox     <= a_ox;
    b_oy     <= a_oy;
  end

  // Stage B: offset times source span; for a sample beat the quotient fits eight bits.
  logic [20:0] b_nx, b_ny;
  assign b_nx = 21'(b_ox * spw);
  assign b_ny = 21'(b_oy * sph);

  fsb_pkg::dv_t dv [0:fsb_pkg::DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else begin
      dv[0].valid <= b_valid;
    end
    dv[0].kind   <= b_kind;
    dv[0].status <= b_status;
    dv[0].addr   <= b_addr;
    dv[0].pix    <= b_pix;
    dv[0].remx   <= b_nx[20:8];
    dv[0].remy   <= b_ny[20:8];
    dv[0].lowx   <= b_nx[7:0];
    dv[0].lowy   <= b_ny[7:0];
  end

  // One restoring-division step per stage on each axis.
  for (genvar i = 0; i < fsb_pkg::DIV_STAGES; i++) begin : g_div
    logic [13:0] tx, ty;
    logic        gx, gy;

    always_comb begin
      tx = {dv[i].remx, dv[i].lowx[7]};
      ty = {dv[i].remy, dv[i].lowy[7]};
      gx = (tx >= {1'b0, rw});
      gy = (ty >= {1'b0, rh});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1].valid <= 1'b0;
      end else begin
        dv[i+1].valid <= dv[i].valid;
      end
      dv[i+1].kind   <= dv[i].kind;
      dv[i+1].status <= dv[i].status;
      dv[i+1].addr   <= dv[i].addr;
      dv[i+1].pix    <= dv[i].pix;
      dv[i+1].remx   <= gx ? 13'(tx - {1'b0, rw}) : tx[12:0];
      dv[i+1].remy   <= gy ? 13'(ty - {1'b0, rh}) : ty[12:0];
      dv[i+1].lowx   <= {dv[i].lowx[6:0], gx};
      dv[i+1].lowy   <= {dv[i].lowy[6:0], gy};
    end
  end

  // Stage C: source coordinates and store address.
  logic [8:0]     c_sx, c_sy;
  fsb_pkg::kind_t c_kind;
  logic [15:0]    c_addr;

  always_comb begin
    c_sx   = {1'b0, sx0} + {1'b0, dv[fsb_pkg::DIV_STAGES].lowx};
    c_sy   = {1'b0, sy0} + {1'b0, dv[fsb_pkg::DIV_STAGES].lowy};
    c_kind = dv[fsb_pkg::DIV_STAGES].kind;
    c_addr = dv[fsb_pkg::DIV_STAGES].addr;
    if (c_kind == fsb_pkg::KIND_SAMPLE) begin
      c_addr = {c_sy[7:0], c_sx[7:0]};
      if (c_sx[8] || c_sy[8]) begin
        c_kind = fsb_pkg::KIND_EMPTY;
      end
    end
  end

  logic             m_valid;
  fsb_pkg::kind_t   m_kind;
  fsb_pkg::status_t m_status;
  logic [15:0]      m_addr;
  logic [31:0]      m_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= dv[fsb_pkg::DIV_STAGES].valid;
    end
    m_kind   <= c_kind;
    m_status <= dv[fsb_pkg::DIV_STAGES].status;
    m_addr   <= c_addr;
    m_pix    <= dv[fsb_pkg::DIV_STAGES].pix;
  end

  // Stage D: the source store. Loads and fetches reach it in beat order.
  logic [31:0] frame_mem [0:fsb_pkg::MAX_SRC_WIDTH*fsb_pkg::MAX_SRC_HEIGHT-1];
  logic [31:0] r_data;
  logic        r_valid;
  fsb_pkg::kind_t   r_kind;
  fsb_pkg::status_t r_status;

  always_ff @(posedge clk) begin
    if (m_valid && m_kind == fsb_pkg::KIND_LOAD) begin
      frame_mem[m_addr] <= m_pix;
    end
    r_data <= frame_mem[m_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      r_valid <= m_valid;
    end
    r_kind   <= m_kind;
    r_status <= m_status;
  end

  // Stage E: brightness gain on B, G and R; alpha passes unchanged.
  logic [31:0] e_gain;

  always_comb begin
    logic [17:0] prod;
    e_gain = {r_data[31:24], 24'd0};
    for (int k = 0; k < 3; k++) begin
      prod = 18'(r_data[8*k +: 8] * gain_eff) + 18'd128;
      e_gain[8*k +: 8] = (prod[17:8] > 10'd255) ? 8'd255 : prod[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= r_valid && (r_kind != fsb_pkg::KIND_LOAD);
    end
    result.status <= r_status;
    case (r_kind)
      fsb_pkg::KIND_BLACK:  result.out_pixel <= fsb_pkg::OPAQUE_BLACK;
      fsb_pkg::KIND_SAMPLE: result.out_pixel <= e_gain;
      default:              result.out_pixel <= '0;
    endcase
  end

endmodule
`default_nettype wire

[test/tb.sv]
// Testbench for the frame scaler with brightness gain: a scoreboard checks every fetched pixel.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int LATENCY = 13;
  localparam int SETUP_CYCLES = 25;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  fsb_pkg::in_t item = '0;
  fsb_pkg::out_t result;
  logic result_valid;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;

  frame_scaler_with_brightness_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result(result), .result_valid(result_valid), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the block's registers and frame store.
  logic [8:0] sh_src_w, sh_src_h;
  logic [12:0] sh_dst_w, sh_dst_h;
  logic [1:0] sh_mode;
  logic sh_flip;
  logic [9:0] sh_gain;
  logic [7:0] sh_guard;
  logic [31:0] frame_mem [0:65535];
  bit written [0:65535];
  fsb_pkg::out_t pixel_queue[$];
  int errors = 0;
  bit quiet = 1'b0;

  function automatic logic [7:0] gain_byte(input logic [7:0] v, input logic [9:0] g);
    logic [31:0] r;
    r = (32'(v) * 32'(g) + 32'd128) >> 8;
    return (r > 32'd255) ? 8'd255 : r[7:0];
  endfunction

  // Works out the expected pixel and the source address it reads, if any.
  function automatic fsb_pkg::out_t scaled_pixel(input logic [11:0] px_i,
                                                 input logic [11:0] py_i,
                                                 output int addr);
    fsb_pkg::out_t o;
    longint unsigned sw, sh, dw, dh, px, py, guard, ly, sx, sy, sa, da, g;
    longint unsigned sx0, sy0, spw, sph, dx0, dy0, rw, rh;
    logic [31:0] s;
    sw = sh_src_w; sh = sh_src_h; dw = sh_dst_w; dh = sh_dst_h;
    px = px_i; py = py_i;
    addr = -1;
    o = '0;
    if (sw == 0 || sh == 0 || dw == 0 || dh == 0) begin
      o.status = fsb_pkg::STATUS_ZERO_DIM;
      return o;
    end
    if (sw > fsb_pkg::MAX_SRC_WIDTH || sh > fsb_pkg::MAX_SRC_HEIGHT
        || dw > fsb_pkg::MAX_DST_DIM || dh > fsb_pkg::MAX_DST_DIM) begin
      o.status = fsb_pkg::STATUS_OVERSIZE;
      return o;
    end
    o.status = fsb_pkg::STATUS_OK;
    if (px >= dw || py >= dh) return o;
    guard = sh_guard;
    if (dw / 2 < guard) guard = dw / 2;
    if (dh / 2 < guard) guard = dh / 2;
    if (py < guard || py >= dh - guard || px < guard || px >= dw - guard) begin
      o.out_pixel = fsb_pkg::OPAQUE_BLACK;
      return o;
    end
    sx0 = 0; sy0 = 0; spw = sw; sph = sh; dx0 = 0; dy0 = 0; rw = dw; rh = dh;
    sa = sw * dh; da = sh * dw;
    if (sh_mode == fsb_pkg::MODE_FIT) begin
      if (sa > da) begin
        rh = dw * sh / sw; if (rh == 0) rh = 1; dy0 = (dh - rh) / 2;
      end else begin
        rw = dh * sw / sh; if (rw == 0) rw = 1; dx0 = (dw - rw) / 2;
      end
    end else if (sh_mode == fsb_pkg::MODE_CROP) begin
      if (sa > da) begin
        spw = sh * dw / dh; if (spw == 0) spw = 1; sx0 = (sw - spw) / 2;
      end else begin
        sph = sw * dh / dw; if (sph == 0) sph = 1; sy0 = (sh - sph) / 2;
      end
    end
    ly = sh_flip ? (dh - 1 - py) : py;
    if (px < dx0 || px >= dx0 + rw || ly < dy0 || ly >= dy0 + rh) return o;
    sx = sx0 + (px - dx0) * spw / rw;
    sy = sy0 + (ly - dy0) * sph / rh;
    if (sx >= fsb_pkg::MAX_SRC_WIDTH || sy * fsb_pkg::MAX_SRC_WIDTH + sx >= 65536) return o;
    addr = int'(sy * fsb_pkg::MAX_SRC_WIDTH + sx);
    g = sh_gain;
    if (g < fsb_pkg::GAIN_MIN) g = fsb_pkg::GAIN_MIN;
    if (g > fsb_pkg::GAIN_MAX) g = fsb_pkg::GAIN_MAX;
    s = frame_mem[addr];
    o.out_pixel = {s[31:24], gain_byte(s[23:16], g[9:0]), gain_byte(s[15:8], g[9:0]),
                   gain_byte(s[7:0], g[9:0])};
    return o;
  endfunction

  task automatic idle_gap();
    if (!quiet && $urandom_range(99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // Sends one beat once busy is low; returns 0 if a fetch would read unwritten store.
  // Start stays high afterwards so that beats can follow back to back.
  task automatic send_item(input fsb_pkg::in_t it, output bit sent);
    fsb_pkg::out_t e;
    int a;
    sent = 1'b0;
    if (it.operation) begin
      e = scaled_pixel(it.fetch_x, it.fetch_y, a);
      if (a >= 0 && !written[a]) return;
    end
    idle_gap();
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (it.operation) begin
      e = scaled_pixel(it.fetch_x, it.fetch_y, a);
      pixel_queue.push_back(e);
    end else begin
      frame_mem[{it.load_y, it.load_x}] = it.load_pixel;
      written[{it.load_y, it.load_x}] = 1'b1;
    end
    sent = 1'b1;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input fsb_pkg::reg_index_t idx, input logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      fsb_pkg::REG_SRC_WIDTH:  sh_src_w = val[8:0];
      fsb_pkg::REG_SRC_HEIGHT: sh_src_h = val[8:0];
      fsb_pkg::REG_DST_WIDTH:  sh_dst_w = val;
      fsb_pkg::REG_DST_HEIGHT: sh_dst_h = val;
      fsb_pkg::REG_SCALE_MODE: sh_mode = val[1:0];
      fsb_pkg::REG_FLIP:       sh_flip = val[0];
      fsb_pkg::REG_GAIN:       sh_gain = val[9:0];
      default:                 sh_guard = val[7:0];
    endcase
  endtask

  task automatic set_geometry(input int sw, input int sh, input int dw, input int dh,
                              input int mode, input int flip, input int gain,
                              input int guard);
    drain();
    write_reg(fsb_pkg::REG_SRC_WIDTH, 13'(sw));
    write_reg(fsb_pkg::REG_SRC_HEIGHT, 13'(sh));
    write_reg(fsb_pkg::REG_DST_WIDTH, 13'(dw));
    write_reg(fsb_pkg::REG_DST_HEIGHT, 13'(dh));
    write_reg(fsb_pkg::REG_SCALE_MODE, 13'(mode));
    write_reg(fsb_pkg::REG_FLIP, 13'(flip));
    write_reg(fsb_pkg::REG_GAIN, 13'(gain));
    write_reg(fsb_pkg::REG_EDGE_GUARD, 13'(guard));
    cfg_valid <= 1'b0;
  endtask

  function automatic fsb_pkg::in_t load_beat(input int x, input int y, input logic [31:0] p);
    fsb_pkg::in_t it;
    it = '0;
    it.operation = 1'b0;
    it.load_x = 8'(x);
    it.load_y = 8'(y);
    it.load_pixel = p;
    it.fetch_x = 12'($urandom);
    it.fetch_y = 12'($urandom);
    return it;
  endfunction

  function automatic fsb_pkg::in_t fetch_beat(input int x, input int y);
    fsb_pkg::in_t it;
    it = '0;
    it.operation = 1'b1;
    it.fetch_x = 12'(x);
    it.fetch_y = 12'(y);
    it.load_x = 8'($urandom);
    it.load_y = 8'($urandom);
    it.load_pixel = $urandom;
    return it;
  endfunction

  // Fills a whole source rectangle so no fetch inside it reads unwritten store.
  task automatic load_frame(input int sw, input int sh);
    bit ok;
    for (int y = 0; y < sh; y++)
      for (int x = 0; x < sw; x++) send_item(load_beat(x, y, $urandom), ok);
  endtask

  task automatic test_directed();
    bit ok;
    // Zero dimensions straight after reset.
    send_item(fetch_beat(0, 0), ok);
    send_item(fetch_beat(4095, 4095), ok);
    load_frame(4, 4);
    send_item(load_beat(255, 255, 32'hFFFF_FFFF), ok);
    send_item(load_beat(0, 255, 32'h0000_0000), ok);
    send_item(load_beat(255, 0, 32'h8080_8080), ok);
    // Oversize source and destination.
    set_geometry(257, 4, 8, 8, fsb_pkg::MODE_STRETCH, 0, 256, 0);
    send_item(fetch_beat(1, 1), ok);
    set_geometry(4, 4, 4097, 8, fsb_pkg::MODE_STRETCH, 0, 256, 0);
    send_item(fetch_beat(1, 1), ok);
    // Gain extremes, fetches outside the destination and spare mode.
    set_geometry(4, 4, 8, 8, fsb_pkg::MODE_SPARE, 1, 1023, 0);
    send_item(fetch_beat(0, 0), ok);
    send_item(fetch_beat(7, 7), ok);
    send_item(fetch_beat(8, 3), ok);
    send_item(fetch_beat(3, 4095), ok);
    set_geometry(4, 4, 8, 8, fsb_pkg::MODE_STRETCH, 0, 0, 0);
    send_item(fetch_beat(5, 2), ok);
    // Edge guard larger than half the destination.
    set_geometry(4, 4, 8, 6, fsb_pkg::MODE_FIT, 0, 512, 255);
    send_item(fetch_beat(3, 3), ok);
    set_geometry(256, 256, 4096, 4096, fsb_pkg::MODE_CROP, 0, 26, 1);
    send_item(fetch_beat(0, 2000), ok);
    send_item(fetch_beat(4095, 4095), ok);
    send_item(fetch_beat(4094, 4094), ok);
    send_item(fetch_beat(2048, 1), ok);
  endtask

  task automatic random_phase(input int count, input bit calm);
    int sw, sh, dw, dh, n;
    bit ok;
    sw = $urandom_range(16, 1);
    sh = $urandom_range(16, 1);
    dw = ($urandom_range(9) == 0) ? $urandom_range(4096, 1) : $urandom_range(40, 1);
    dh = ($urandom_range(9) == 0) ? $urandom_range(4096, 1) : $urandom_range(40, 1);
    if ($urandom_range(15) == 0) sw = 0;
    set_geometry(sw, sh, dw, dh, $urandom_range(3), $urandom_range(1),
                 $urandom_range(1023), ($urandom_range(2) == 0) ? $urandom_range(255)
                                                               : $urandom_range(3));
    load_frame(sw, sh);
    quiet = calm;
    n = 0;
    while (n < count) begin
      if ($urandom_range(9) == 0) begin
        send_item(load_beat($urandom_range(255), $urandom_range(255), $urandom), ok);
      end else if ($urandom_range(9) == 0) begin
        send_item(fetch_beat($urandom_range(4095), $urandom_range(4095)), ok);
      end else begin
        send_item(fetch_beat($urandom_range(dw + 1), $urandom_range(dh + 1)), ok);
      end
      if (ok) n++;
    end
    quiet = 1'b0;
  endtask

  task automatic test_random();
    for (int p = 0; p < 7; p++) random_phase(60, p == 3);
  endtask

  // The sender waits for every outstanding pixel before carrying on.
  task automatic test_pause();
    bit ok;
    random_phase(20, 0);
    start <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    send_item(fetch_beat(0, 0), ok);
  endtask

  always @(posedge clk) begin
    fsb_pkg::out_t e;
    if (!rst && result_valid) begin
      if (pixel_queue.size() == 0) begin
        $error("unexpected result: out_pixel %h status %0d", result.out_pixel, result.status);
        errors++;
      end else begin
        e = pixel_queue.pop_front();
        if (result.out_pixel !== e.out_pixel) begin
          $error("out_pixel expected %h actual %h", e.out_pixel, result.out_pixel);
          errors++;
        end
        if (result.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, result.status);
          errors++;
        end
      end
    end
  end

  initial begin
    sh_src_w = '0; sh_src_h = '0; sh_dst_w = '0; sh_dst_h = '0;
    sh_mode = fsb_pkg::MODE_STRETCH; sh_flip = 1'b0; sh_gain = fsb_pkg::GAIN_RESET;
    sh_guard = '0;
    foreach (frame_mem[i]) begin
      frame_mem[i] = '0;
      written[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (SETUP_CYCLES) @(posedge clk);
    test_directed();
    test_random();
    test_pause();
    drain();
    if (pixel_queue.size() != 0) errors++;
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
sv/fsb_pkg.sv
sv/frame_scaler_with_brightness_unit.sv
test/tb.sv
